// ----- hdl/lint2d_pkg.sv -----
package lint2d_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned THR_WIDTH       = 32;
  localparam int unsigned NUM_COORDS      = 2;

  // parallel threshold of 1e-5, in units of 2^-(2*frac_bits), rounded to nearest
  function automatic logic [THR_WIDTH-1:0] thr_reset(input int unsigned frac_bits);
    logic [63:0] one;
    one = 64'd1 << (2 * frac_bits);
    return THR_WIDTH'((one + 64'd50000) / 64'd100000);
  endfunction

endpackage

// ----- hdl/line_intersection_2d_core.sv -----
// channel   | direction | tdata (low bit up)                          | tuser (low bit up)
// s_axis    | in        | line1_point_x, line1_point_y, line1_dir_x,  | -
//           |           | line1_dir_y, line2_point_x, line2_point_y,  |
//           |           | line2_dir_x, line2_dir_y                    |
// m_axis    | out       | cross_x, cross_y, zero pad to bytes         | is_parallel, overflowed
// cfg       | in        | parallel_threshold on cfg_we_i              | -
//
// one transfer per cycle in while the skid entry is empty, and out while the receiver is ready;
// the pipe is seven stages of products, sums and magnitudes and a range-check stage, then
// the restoring divider that retires one quotient bit per stage (COORD_WIDTH+1 stages),
// then one saturation stage and the output register.
// reset clears the valid bits and loads the threshold; payload registers are not reset.
// an output register plus one skid entry let the pipe keep moving while a result waits;
// the whole pipe stalls only while the skid entry is occupied.
module line_intersection_2d_core #(
  parameter int unsigned COORD_WIDTH = lint2d_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = lint2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lint2d_pkg::THR_WIDTH-1:0]       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // line1_point_x, line1_point_y, line1_dir_x, line1_dir_y,
  // line2_point_x, line2_point_y, line2_dir_x, line2_dir_y
  input  logic [8*COORD_WIDTH-1:0]               s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // cross_x, cross_y, zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // is_parallel, overflowed
  output logic [1:0]                             m_axis_tuser
);
  import lint2d_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;          // point differences
  localparam int unsigned PW   = 2 * W + 1;      // cross product
  localparam int unsigned NW   = 2 * W + 2;      // numerator
  localparam int unsigned NNW  = 2 * W + 3;      // negated numerator
  localparam int unsigned LW   = W + 1;          // low part of split product
  localparam int unsigned HW   = NNW - LW;       // high part of split product
  localparam int unsigned PLW  = LW + 1 + W;
  localparam int unsigned PHW  = HW + W;
  localparam int unsigned NUMW = NNW + W;        // scaled numerator
  localparam int unsigned AW   = NUMW + 1;       // dividend
  localparam int unsigned BW   = PW + 1;         // divisor
  localparam int unsigned QW   = W + 1;          // quotient bits kept
  localparam int unsigned RW   = W + 3;          // coordinate before clamp
  localparam int unsigned XW   = PW + 1;         // threshold compare
  localparam int unsigned ODW  = ((2 * W + 7) / 8) * 8;
  localparam int unsigned NPS  = QW + 9;         // pipe stages before output register
  localparam logic [THR_WIDTH-1:0] THR_RST = thr_reset(FRAC_BITS);
  localparam logic signed [RW-1:0] SAT_HI  = RW'((65'sd1 <<< (W - 1)) - 65'sd1);
  localparam logic signed [RW-1:0] SAT_LO  = -SAT_HI - RW'(1);

  logic [THR_WIDTH-1:0] thr_q;
  logic [NPS-1:0]       vld_q;
  logic                 ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // input unpack
  logic signed [W-1:0] in_f [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      in_f[k] = s_axis_tdata[k*W +: W];
    end
  end

  // stage 1: point differences
  logic signed [DW-1:0] s1_ex_q, s1_ey_q;
  logic signed [W-1:0]  s1_dx1_q, s1_dy1_q, s1_dx2_q, s1_dy2_q, s1_x2_q, s1_y2_q;
  // stage 2: products
  logic signed [2*W-1:0] s2_p1_q, s2_p2_q;
  logic signed [PW-1:0]  s2_p3_q, s2_p4_q;
  logic signed [W-1:0]   s2_d_q [NUM_COORDS];
  logic signed [W-1:0]   s2_base_q [NUM_COORDS];
  // stage 3: cross product and numerator
  logic signed [PW-1:0] s3_t_q;
  logic signed [NW-1:0] s3_n_q;
  logic signed [W-1:0]  s3_d_q [NUM_COORDS];
  logic signed [W-1:0]  s3_base_q [NUM_COORDS];
  // stage 4: split products of -N by each direction, divisor magnitude, parallel test
  logic signed [PLW-1:0] s4_plo_q [NUM_COORDS];
  logic signed [PHW-1:0] s4_phi_q [NUM_COORDS];
  logic [PW-1:0]         s4_bt_q;
  logic                  s4_tneg_q, s4_par_q;
  logic signed [W-1:0]   s4_base_q [NUM_COORDS];
  // stage 5: joined numerator
  logic signed [NUMW-1:0] s5_num_q [NUM_COORDS];
  logic [PW-1:0]          s5_bt_q;
  logic                   s5_tneg_q, s5_par_q;
  logic signed [W-1:0]    s5_base_q [NUM_COORDS];
  // stage 6: magnitudes and signs
  logic [NUMW-1:0]     s6_an_q [NUM_COORDS];
  logic                s6_neg_q [NUM_COORDS];
  logic [PW-1:0]       s6_bt_q;
  logic                s6_par_q;
  logic signed [W-1:0] s6_base_q [NUM_COORDS];
  // stage 7: rounding dividend and divisor
  logic [AW-1:0]       s7_a_q [NUM_COORDS];
  logic                s7_neg_q [NUM_COORDS];
  logic [BW-1:0]       s7_b_q;
  logic                s7_par_q;
  logic signed [W-1:0] s7_base_q [NUM_COORDS];
  // divider: entry 0 is the range check, entries 1..QW retire one quotient bit each
  logic [AW-1:0]       dv_rem_q  [QW+1][NUM_COORDS];
  logic [QW-1:0]       dv_quo_q  [QW+1][NUM_COORDS];
  logic                dv_big_q  [QW+1][NUM_COORDS];
  logic                dv_neg_q  [QW+1][NUM_COORDS];
  logic signed [W-1:0] dv_base_q [QW+1][NUM_COORDS];
  logic [BW-1:0]       dv_b_q    [QW+1];
  logic                dv_par_q  [QW+1];
  // final saturation stage
  logic [W-1:0] fs_c_q [NUM_COORDS];
  logic         fs_par_q, fs_ovf_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NPS-2:0], s_axis_tvalid};
    end
  end

  // stage 4 combinational terms
  logic signed [NNW-1:0] s4_nn;
  logic signed [XW-1:0]  s4_thr, s4_tx;
  always_comb begin
    s4_nn  = -NNW'(s3_n_q);
    s4_thr = $signed(XW'({1'b0, thr_q}));
    s4_tx  = XW'(s3_t_q);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1_ex_q  <= DW'(in_f[0]) - DW'(in_f[4]);
      s1_ey_q  <= DW'(in_f[1]) - DW'(in_f[5]);
      s1_dx1_q <= in_f[2];
      s1_dy1_q <= in_f[3];
      s1_x2_q  <= in_f[4];
      s1_y2_q  <= in_f[5];
      s1_dx2_q <= in_f[6];
      s1_dy2_q <= in_f[7];

      s2_p1_q      <= (2*W)'(s1_dy1_q) * (2*W)'(s1_dx2_q);
      s2_p2_q      <= (2*W)'(s1_dx1_q) * (2*W)'(s1_dy2_q);
      s2_p3_q      <= PW'(s1_dx1_q) * PW'(s1_ey_q);
      s2_p4_q      <= PW'(s1_dy1_q) * PW'(s1_ex_q);
      s2_d_q[0]    <= s1_dx2_q;
      s2_d_q[1]    <= s1_dy2_q;
      s2_base_q[0] <= s1_x2_q;
      s2_base_q[1] <= s1_y2_q;

      s3_t_q    <= PW'(s2_p1_q) - PW'(s2_p2_q);
      s3_n_q    <= NW'(s2_p3_q) - NW'(s2_p4_q);
      s3_d_q    <= s2_d_q;
      s3_base_q <= s2_base_q;

      for (int c = 0; c < NUM_COORDS; c++) begin
        s4_plo_q[c] <= $signed(PLW'({1'b0, s4_nn[LW-1:0]})) * PLW'(s3_d_q[c]);
        s4_phi_q[c] <= PHW'($signed(s4_nn[NNW-1:LW])) * PHW'(s3_d_q[c]);
      end
      s4_bt_q   <= s3_t_q[PW-1] ? PW'(-s3_t_q) : PW'(s3_t_q);
      s4_tneg_q <= s3_t_q[PW-1];
      // zero cross product always counts as parallel
      s4_par_q  <= (s3_t_q == '0) ||
                   (s3_t_q[PW-1] ? (s4_tx > -s4_thr) : (s4_tx < s4_thr));
      s4_base_q <= s3_base_q;

      for (int c = 0; c < NUM_COORDS; c++) begin
        s5_num_q[c] <= (NUMW'(s4_phi_q[c]) <<< LW) + NUMW'(s4_plo_q[c]);
      end
      s5_bt_q   <= s4_bt_q;
      s5_tneg_q <= s4_tneg_q;
      s5_par_q  <= s4_par_q;
      s5_base_q <= s4_base_q;

      for (int c = 0; c < NUM_COORDS; c++) begin
        s6_an_q[c]  <= s5_num_q[c][NUMW-1] ? NUMW'(-s5_num_q[c]) : NUMW'(s5_num_q[c]);
        s6_neg_q[c] <= s5_num_q[c][NUMW-1] ^ s5_tneg_q;
      end
      s6_bt_q   <= s5_bt_q;
      s6_par_q  <= s5_par_q;
      s6_base_q <= s5_base_q;

      // round to nearest, ties away: (2a + b) / 2b
      for (int c = 0; c < NUM_COORDS; c++) begin
        s7_a_q[c] <= (AW'(s6_an_q[c]) << 1) + AW'(s6_bt_q);
      end
      s7_neg_q  <= s6_neg_q;
      s7_b_q    <= BW'(s6_bt_q) << 1;
      s7_par_q  <= s6_par_q;
      s7_base_q <= s6_base_q;

      // quotient at or above 2^QW saturates anyway
      for (int c = 0; c < NUM_COORDS; c++) begin
        dv_rem_q[0][c] <= s7_a_q[c];
        dv_quo_q[0][c] <= '0;
        dv_big_q[0][c] <= s7_a_q[c] >= (AW'(s7_b_q) << QW);
      end
      dv_neg_q[0]  <= s7_neg_q;
      dv_base_q[0] <= s7_base_q;
      dv_b_q[0]    <= s7_b_q;
      dv_par_q[0]  <= s7_par_q;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [AW-1:0] bsh;
    logic          ge [NUM_COORDS];
    always_comb begin
      bsh = AW'(dv_b_q[j-1]) << (QW - j);
      for (int c = 0; c < NUM_COORDS; c++) begin
        ge[c] = dv_rem_q[j-1][c] >= bsh;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce) begin
        for (int c = 0; c < NUM_COORDS; c++) begin
          dv_rem_q[j][c] <= ge[c] ? dv_rem_q[j-1][c] - bsh : dv_rem_q[j-1][c];
          dv_quo_q[j][c] <= {dv_quo_q[j-1][c][QW-2:0], ge[c]};
        end
        dv_big_q[j]  <= dv_big_q[j-1];
        dv_neg_q[j]  <= dv_neg_q[j-1];
        dv_base_q[j] <= dv_base_q[j-1];
        dv_b_q[j]    <= dv_b_q[j-1];
        dv_par_q[j]  <= dv_par_q[j-1];
      end
    end
  end

  // saturation
  logic [QW-1:0]        fs_qe  [NUM_COORDS];
  logic signed [RW-1:0] fs_r   [NUM_COORDS];
  logic [W-1:0]         fs_c   [NUM_COORDS];
  logic                 fs_sat [NUM_COORDS];
  always_comb begin
    for (int c = 0; c < NUM_COORDS; c++) begin
      fs_qe[c] = dv_big_q[QW][c] ? '1 : dv_quo_q[QW][c];
      fs_r[c]  = RW'(dv_base_q[QW][c]) +
                 (dv_neg_q[QW][c] ? -$signed(RW'(fs_qe[c])) : $signed(RW'(fs_qe[c])));
      fs_sat[c] = (fs_r[c] > SAT_HI) || (fs_r[c] < SAT_LO);
      if (dv_par_q[QW]) begin
        fs_c[c] = '0;
      end else if (fs_r[c] > SAT_HI) begin
        fs_c[c] = SAT_HI[W-1:0];
      end else if (fs_r[c] < SAT_LO) begin
        fs_c[c] = SAT_LO[W-1:0];
      end else begin
        fs_c[c] = fs_r[c][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      fs_c_q   <= fs_c;
      fs_par_q <= dv_par_q[QW];
      fs_ovf_q <= !dv_par_q[QW] && (fs_sat[0] || fs_sat[1]);
    end
  end

  // output register and skid entry
  logic         ob_v_q, sk_v_q;
  logic [W-1:0] ob_c_q [NUM_COORDS];
  logic [W-1:0] sk_c_q [NUM_COORDS];
  logic         ob_par_q, ob_ovf_q, sk_par_q, sk_ovf_q;
  logic         take, ob_free;

  assign ce      = !sk_v_q;
  assign take    = ce && vld_q[NPS-1];
  assign ob_free = !ob_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (ob_free) begin
      ob_v_q <= sk_v_q || take;
      sk_v_q <= 1'b0;
    end else if (take) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_free) begin
      if (sk_v_q) begin
        ob_c_q   <= sk_c_q;
        ob_par_q <= sk_par_q;
        ob_ovf_q <= sk_ovf_q;
      end else begin
        ob_c_q   <= fs_c_q;
        ob_par_q <= fs_par_q;
        ob_ovf_q <= fs_ovf_q;
      end
    end else if (take) begin
      sk_c_q   <= fs_c_q;
      sk_par_q <= fs_par_q;
      sk_ovf_q <= fs_ovf_q;
    end
  end

  assign s_axis_tready = ce;
  assign m_axis_tvalid = ob_v_q;
  assign m_axis_tdata  = ODW'({ob_c_q[1], ob_c_q[0]});
  assign m_axis_tuser  = {ob_ovf_q, ob_par_q};

`ifndef ASSERT_OFF
  // a parallel result carries zero coordinates and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("parallel result with nonzero payload");

  // input is held off only while the output and skid entry are both full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output");

  // an overflow flag means one coordinate sits at a range bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      ob_c_q[0] == SAT_HI[W-1:0] || ob_c_q[0] == SAT_LO[W-1:0] ||
      ob_c_q[1] == SAT_HI[W-1:0] || ob_c_q[1] == SAT_LO[W-1:0])
    else $error("overflow flagged without a saturated coordinate");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int OUT_W = ((2*CW+7)/8)*8;
  localparam int LATENCY = CW + 11;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] l2dy, l2dx, l2py, l2px, l1dy, l1dx, l1py, l1px;
  } line_pair_t;

  typedef struct packed {
    logic       is_parallel;
    logic       overflowed;
    logic [CW-1:0] cross_x;
    logic [CW-1:0] cross_y;
  } crossing_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [lint2d_pkg::THR_WIDTH-1:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [8*CW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  line_intersection_2d_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  logic [31:0] threshold;
  crossing_t expected_crossings[$];
  int mismatches;
  int idle_cycles;
  bit hold_off_req;
  bit busy_sender;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // rounded quotient added to base, then clamped to the coordinate range
  function automatic logic [CW-1:0] solve_axis(input logic signed [CW-1:0] base,
                                               input logic signed [191:0] num,
                                               input logic signed [191:0] den,
                                               inout logic ovf);
    logic signed [191:0] mag_n, mag_d, q, r;
    logic negative;
    negative = num[191] ^ den[191];
    mag_n = num[191] ? -num : num;
    mag_d = den[191] ? -den : den;
    q = (2*mag_n + mag_d) / (2*mag_d);
    r = 192'(base) + (negative ? -q : q);
    if (r > 192'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (r < -192'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return r[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(input line_pair_t p);
    logic signed [191:0] t, n, abs_t;
    crossing_t c;
    logic ovf;
    t = 192'(p.l1dy) * 192'(p.l2dx) - 192'(p.l1dx) * 192'(p.l2dy);
    n = 192'(p.l1dx) * (192'(p.l1py) - 192'(p.l2py))
      - 192'(p.l1dy) * (192'(p.l1px) - 192'(p.l2px));
    abs_t = t[191] ? -t : t;
    c = '0;
    ovf = 1'b0;
    if (t == 0 || abs_t < 192'(threshold)) begin
      c.is_parallel = 1'b1;
    end else begin
      c.cross_x = solve_axis(p.l2px, -n * 192'(p.l2dx), t, ovf);
      c.cross_y = solve_axis(p.l2py, -n * 192'(p.l2dy), t, ovf);
      c.overflowed = ovf;
    end
    return c;
  endfunction

  // sender state: bursts then gaps
  int burst_left, gap_left;

  // tvalid stays high between items of a burst and drops only for a gap
  task automatic send_pair(input line_pair_t p);
    if (burst_left == 0) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_crossings.push_back(predict_crossing(p));
  endtask

  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_crossings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    finish_stream();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = value;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic line_pair_t rand_pair();
    line_pair_t p;
    p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // some share a direction, scaled, to hit the parallel test
    if ($urandom_range(0, 7) == 0) begin
      p.l2dx = p.l1dx * 2;
      p.l2dy = p.l1dy * 2;
    end
    return p;
  endfunction

  task automatic test_directed();
    line_pair_t p;
    // axes crossing at (0, 0)
    send_pair({32'h10000, 32'h0, 32'h20000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0});
    // identical lines, zero cross product
    p = {32'h10000, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0};
    send_pair(p);
    // all zero
    send_pair('0);
    // all max, all min
    send_pair({8{32'h7fffffff}});
    send_pair({8{32'h80000000}});
    // far lines whose cross product falls below the default threshold
    send_pair({32'h0, 32'h1, 32'h7fffffff, 32'h7fffffff,
               32'h1, 32'h0, 32'h80000000, 32'h80000000});
    send_pair({32'h1, 32'h0, 32'h80000000, 32'h7fffffff,
               32'h0, 32'h1, 32'h7fffffff, 32'h80000000});
    // tiny cross product below the default threshold
    send_pair({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h100, 32'h0, 32'h0});
    send_pair({32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0});
    // vertical parallel lines, both signs, zero cross product
    send_pair({32'h3, 32'h0, 32'h0, 32'h0, 32'h2, 32'h0, 32'h0, 32'h1});
    send_pair({32'hfffffffd, 32'h0, 32'h0, 32'h0, 32'h2, 32'h0, 32'h0, 32'h1});
    for (int i = 0; i < 8; i++) begin
      p = {8{32'h0}};
      p[i*CW +: CW] = 32'h7fffffff;
      p[((i+3)%8)*CW +: CW] = 32'hffff0000;
      send_pair(p);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_pair(rand_pair());
  endtask

  task automatic test_thresholds();
    write_threshold(32'h0);
    send_pair({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0});
    send_pair({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    test_random(300);
    write_threshold(32'hffffffff);
    test_random(300);
    write_threshold($urandom);
    test_random(300);
    write_threshold(lint2d_pkg::thr_reset(16));
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random(200);
    hold_off_req = 1'b0;
  endtask

  // receiver: stall pattern plus a long hold-off when asked
  initial begin
    int phase;
    m_axis_tready <= 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (phase < 20) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // result check
  always @(posedge clk_i) begin
    crossing_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cross_x = m_axis_tdata[CW-1:0];
      got.cross_y = m_axis_tdata[2*CW-1:CW];
      got.is_parallel = m_axis_tuser[0];
      got.overflowed = m_axis_tuser[1];
      if (expected_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", got);
      end else begin
        want = expected_crossings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || !busy_sender)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    burst_left = 0;
    gap_left = 0;
    busy_sender = 1'b1;
    threshold = lint2d_pkg::thr_reset(16);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(400);
    test_thresholds();
    finish_stream();
    busy_sender = 1'b0;
    if (mismatches == 0 && expected_crossings.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

// ----- line_intersection_2d_core.f -----
hdl/lint2d_pkg.sv
hdl/line_intersection_2d_core.sv
verif/testbench.sv
